[src/frp_pkg.sv]
package frp_pkg;

    // Field widths of the text stream and the result stream.
    localparam int ByteW = 8;
    localparam int KindW = 2;

    // Characters that steer the parser.
    localparam logic [ByteW-1:0] ChGt    = 8'h3E;
    localparam logic [ByteW-1:0] ChLf    = 8'h0A;
    localparam logic [ByteW-1:0] ChSpace = 8'h20;
    localparam logic [ByteW-1:0] ChTab   = 8'h09;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BASES  = 2'd2,
        PH_ERROR  = 2'd3
    } t_phase;

    // Kind of a result item.
    typedef enum logic [KindW-1:0] {
        K_HEADER = 2'd0,
        K_BASE   = 2'd1,
        K_END    = 2'd2,
        K_ERROR  = 2'd3
    } t_kind;

    // One input item as held in the input register.
    typedef struct packed {
        logic [ByteW-1:0] byte_in;
        logic             end_of_stream;
    } t_item;

    // One decoded result, with a flag that says whether there is one.
    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [ByteW-1:0] value;
    } t_result;

    // IUPAC base letters: A-Z and a-z except E F I J L O P Q U X Z.
    function automatic logic is_base(input logic [ByteW-1:0] c);
        logic [ByteW-1:0] u;
        logic             letter;
        u      = c & 8'hDF;
        letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
        if (!letter) begin
            return 1'b0;
        end
        unique case (u)
            8'h45, 8'h46, 8'h49, 8'h4A, 8'h4C, 8'h4F,
            8'h50, 8'h51, 8'h55, 8'h58, 8'h5A: return 1'b0;
            default: return 1'b1;
        endcase
    endfunction

endpackage

[src/frp_if.sv]
// Input channel: one text byte or an end-of-stream mark per item.
interface frp_in_if;
    logic                        valid;
    logic                        ready;
    logic [frp_pkg::ByteW-1:0]   byte_in;
    logic                        end_of_stream;

    modport source (output valid, output byte_in, output end_of_stream, input ready);
    modport sink   (input valid, input byte_in, input end_of_stream, output ready);
endinterface

// Result channel: one tagged character, record end or error per item.
interface frp_out_if;
    logic                        valid;
    logic                        ready;
    frp_pkg::t_kind              kind;
    logic [frp_pkg::ByteW-1:0]   value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

[src/fasta_record_parser_top.sv]
// Channel   Direction  Handshake     Payload
// i_in      sink       valid/ready   byte_in[7:0], end_of_stream
// o_out     source     valid/ready   kind[1:0], value[7:0]
// i_cfg_*   input      write enable  collapse_runs (bit 0 of i_cfg_wdata)
//
// One item per cycle sustained while the result side does not stall; each
// item passes an input register, the phase decode and the result register,
// which presents its result. The phase update in the decode sets that rate.
// Reset is synchronous and active low; it returns the parser to the idle
// phase with collapsing off. A stalled result holds in the result register
// while the input register still fills, and i_in.ready drops only when both
// are full.
module fasta_record_parser_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    frp_in_if.sink    i_in,
    frp_out_if.source o_out,
    input  logic  i_cfg_we,
    input  logic  i_cfg_wdata
);

    frp_pkg::t_item   in_item;
    frp_pkg::t_item   s1_item;
    frp_pkg::t_result res;
    logic             s1_valid;
    logic             advance;
    logic             r_collapse;
    logic             r_out_valid;
    logic             n_out_valid;
    frp_pkg::t_kind   r_out_kind;
    logic [frp_pkg::ByteW-1:0] r_out_value;

    assign in_item = '{byte_in: i_in.byte_in, end_of_stream: i_in.end_of_stream};

    // The held item is consumed when the result register is free or drains.
    assign advance = s1_valid && (!r_out_valid || o_out.ready);

    frp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_ready   (i_in.ready),
        .o_valid   (s1_valid),
        .o_item    (s1_item)
    );

    frp_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_collapse (r_collapse),
        .i_step     (advance),
        .i_item     (s1_item),
        .o_res      (res)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collapse <= 1'b0;
        end else if (i_cfg_we) begin
            r_collapse <= i_cfg_wdata;
        end
    end

    // Result register: loads on a consumed item, otherwise holds or empties.
    always_comb begin
        if (advance) begin
            n_out_valid = res.valid;
        end else begin
            n_out_valid = r_out_valid && !o_out.ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.valid) begin
            r_out_kind  <= res.kind;
            r_out_value <= res.value;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.kind  = r_out_kind;
    assign o_out.value = r_out_value;

endmodule

[src/frp_in_stage.sv]
module frp_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  frp_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_ready,
    output logic           o_valid,
    output frp_pkg::t_item o_item
);

    logic           r_valid;
    logic           n_valid;
    frp_pkg::t_item r_item;

    // The register takes a new item when empty or when its item moves on.
    assign o_ready = !r_valid || i_advance;
    assign n_valid = o_ready ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[src/frp_decode.sv]
module frp_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_collapse,
    input  logic             i_step,
    input  frp_pkg::t_item   i_item,
    output frp_pkg::t_result o_res
);

    frp_pkg::t_phase             r_phase;
    frp_pkg::t_phase             n_phase;
    logic [frp_pkg::ByteW-1:0]   r_prev;
    logic [frp_pkg::ByteW-1:0]   n_prev;
    logic                        r_have_prev;
    logic                        n_have_prev;
    logic [frp_pkg::ByteW-1:0]   c;

    assign c = i_item.byte_in;

    // Next phase and the result of the byte in the input register.
    always_comb begin
        n_phase     = r_phase;
        n_prev      = r_prev;
        n_have_prev = r_have_prev;
        o_res       = '{valid: 1'b0, kind: frp_pkg::K_HEADER, value: '0};
        if (i_item.end_of_stream) begin
            n_phase     = frp_pkg::PH_IDLE;
            n_have_prev = 1'b0;
            if (r_phase == frp_pkg::PH_HEADER) begin
                o_res = '{valid: 1'b1, kind: frp_pkg::K_ERROR, value: '0};
            end else if (r_phase == frp_pkg::PH_BASES) begin
                o_res = '{valid: 1'b1, kind: frp_pkg::K_END, value: '0};
            end
        end else begin
            unique case (r_phase)
                frp_pkg::PH_IDLE: begin
                    if (c == frp_pkg::ChSpace || c == frp_pkg::ChTab) begin
                        n_phase = frp_pkg::PH_IDLE;
                    end else if (c == frp_pkg::ChGt) begin
                        n_phase     = frp_pkg::PH_HEADER;
                        n_have_prev = 1'b0;
                    end else begin
                        n_phase     = frp_pkg::PH_ERROR;
                        n_have_prev = 1'b0;
                        o_res = '{valid: 1'b1, kind: frp_pkg::K_ERROR, value: '0};
                    end
                end
                frp_pkg::PH_HEADER: begin
                    if (c == frp_pkg::ChLf) begin
                        n_phase     = frp_pkg::PH_BASES;
                        n_have_prev = 1'b0;
                    end else begin
                        o_res = '{valid: 1'b1, kind: frp_pkg::K_HEADER, value: c};
                    end
                end
                frp_pkg::PH_BASES: begin
                    if (c == frp_pkg::ChGt) begin
                        n_phase     = frp_pkg::PH_HEADER;
                        n_have_prev = 1'b0;
                        o_res = '{valid: 1'b1, kind: frp_pkg::K_END, value: '0};
                    end else if (frp_pkg::is_base(c)
                                 && !(i_collapse && r_have_prev && r_prev == c)) begin
                        n_prev      = c;
                        n_have_prev = 1'b1;
                        o_res = '{valid: 1'b1, kind: frp_pkg::K_BASE, value: c};
                    end
                end
                frp_pkg::PH_ERROR: begin
                    n_phase = frp_pkg::PH_ERROR;
                end
                default: begin
                    n_phase = frp_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // State moves only when the held item is consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= frp_pkg::PH_IDLE;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_prev      <= n_prev;
            r_have_prev <= n_have_prev;
        end
    end

endmodule

[test/frp_checker.sv]
module frp_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    frp_in_if    i_in,
    frp_out_if   i_out,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // One tagged character that the parser is expected to produce.
    typedef struct {
        frp_pkg::t_kind            kind;
        logic [frp_pkg::ByteW-1:0] value;
    } t_tagged_char;

    t_tagged_char              chars_due[$];
    frp_pkg::t_phase           parse_phase;
    logic [frp_pkg::ByteW-1:0] last_base;
    logic                      seen_base;
    logic                      collapse_on;
    int                        fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = chars_due.size();

    // Letters of the IUPAC nucleotide alphabet, either case.
    function automatic logic iupac_letter(input logic [frp_pkg::ByteW-1:0] c);
        logic [frp_pkg::ByteW-1:0] up;
        up = (c >= "a" && c <= "z") ? c - 8'h20 : c;
        if (up < "A" || up > "Z") begin
            return 1'b0;
        end
        return !(up inside {"E", "F", "I", "J", "L", "O", "P", "Q", "U", "X", "Z"});
    endfunction

    function automatic void expect_char(input frp_pkg::t_kind kind,
                                        input logic [frp_pkg::ByteW-1:0] value);
        t_tagged_char tc;
        tc.kind  = kind;
        tc.value = value;
        chars_due.push_back(tc);
    endfunction

    // Advance the parser by one accepted item and queue what it produces.
    function automatic void parse_item(input logic [frp_pkg::ByteW-1:0] c, input logic eos);
        if (eos) begin
            if (parse_phase == frp_pkg::PH_HEADER) begin
                expect_char(frp_pkg::K_ERROR, '0);
            end else if (parse_phase == frp_pkg::PH_BASES) begin
                expect_char(frp_pkg::K_END, '0);
            end
            parse_phase = frp_pkg::PH_IDLE;
            seen_base   = 1'b0;
            return;
        end
        unique case (parse_phase)
            frp_pkg::PH_IDLE: begin
                if (c == frp_pkg::ChGt) begin
                    parse_phase = frp_pkg::PH_HEADER;
                    seen_base   = 1'b0;
                end else if (c != frp_pkg::ChSpace && c != frp_pkg::ChTab) begin
                    parse_phase = frp_pkg::PH_ERROR;
                    seen_base   = 1'b0;
                    expect_char(frp_pkg::K_ERROR, '0);
                end
            end
            frp_pkg::PH_HEADER: begin
                if (c == frp_pkg::ChLf) begin
                    parse_phase = frp_pkg::PH_BASES;
                    seen_base   = 1'b0;
                end else begin
                    expect_char(frp_pkg::K_HEADER, c);
                end
            end
            frp_pkg::PH_BASES: begin
                if (c == frp_pkg::ChGt) begin
                    parse_phase = frp_pkg::PH_HEADER;
                    seen_base   = 1'b0;
                    expect_char(frp_pkg::K_END, '0);
                end else if (iupac_letter(c)
                             && !(collapse_on && seen_base && last_base == c)) begin
                    last_base = c;
                    seen_base = 1'b1;
                    expect_char(frp_pkg::K_BASE, c);
                end
            end
            default: begin
                // Error phase: everything is dropped until end of stream.
            end
        endcase
    endfunction

    // Track register writes and items on both channels at each edge.
    always @(posedge i_clk) begin
        t_tagged_char want;
        if (!i_rst_n) begin
            parse_phase = frp_pkg::PH_IDLE;
            last_base   = '0;
            seen_base   = 1'b0;
            collapse_on = 1'b0;
            chars_due.delete();
        end else begin
            if (i_cfg_we) begin
                collapse_on = i_cfg_wdata;
            end
            if (i_out.valid && i_out.ready) begin
                if (chars_due.size() == 0) begin
                    $error("unexpected result item: kind %0d value 0x%02h",
                           i_out.kind, i_out.value);
                    fails++;
                end else begin
                    want = chars_due.pop_front();
                    if (i_out.kind != want.kind) begin
                        $error("kind mismatch: expected %0d, actual %0d", want.kind, i_out.kind);
                        fails++;
                    end
                    if (i_out.value != want.value) begin
                        $error("value mismatch: expected 0x%02h, actual 0x%02h",
                               want.value, i_out.value);
                        fails++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                parse_item(i_in.byte_in, i_in.end_of_stream);
            end
        end
    end

endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [frp_pkg::ByteW-1:0] t_byte;

    localparam int CycleLimit  = 300000;
    localparam int DrainCycles = 6;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cfg_we    = 1'b0;
    logic cfg_wdata = 1'b0;
    bit   calm      = 1'b0;
    int   items_sent = 0;
    int   cycles     = 0;
    int   fail_count;
    int   pending;

    frp_in_if  in_ch ();
    frp_out_if out_ch ();

    fasta_record_parser_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    frp_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The result side stalls at random unless the calm stretch is on.
    always @(posedge clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= 21);
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Offer one item, with random gaps ahead of it, and wait for its acceptance.
    // Valid stays high afterwards so back-to-back items need no toggle.
    task automatic send_item(input t_byte ch, input logic eos);
        while (!calm && $urandom_range(99) < 21) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.byte_in       <= ch;
        in_ch.end_of_stream <= eos;
        do begin
            @(posedge clk);
        end while (!in_ch.ready);
        items_sent++;
    endtask

    // Stop sending and let every expected result, and any item still in flight, come out.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic set_collapse(input logic on);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= on;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Next character of a sequence body: mostly bases with runs, some junk.
    function automatic t_byte pick_seq_char(input t_byte prev);
        string letters;
        int    roll;
        t_byte ch;
        letters = "ACGTNRYKMSWBDHVacgtnrykmswbdhv";
        roll    = $urandom_range(99);
        if (roll < 25) begin
            ch = prev;
        end else if (roll < 80) begin
            ch = letters[$urandom_range(letters.len() - 1)];
        end else if (roll < 88) begin
            ch = frp_pkg::ChLf;
        end else begin
            ch = t_byte'($urandom_range(255));
            if (ch == frp_pkg::ChGt) begin
                ch = "N";
            end
        end
        return ch;
    endfunction

    // A well-formed file of a few records, now and then cut off inside a header.
    task automatic send_file();
        int    recs;
        int    len;
        t_byte ch;
        t_byte prev;
        recs = $urandom_range(1, 3);
        repeat ($urandom_range(0, 2)) begin
            send_item($urandom_range(1) ? frp_pkg::ChSpace : frp_pkg::ChTab, 1'b0);
        end
        for (int r = 0; r < recs; r++) begin
            send_item(frp_pkg::ChGt, 1'b0);
            len = $urandom_range(0, 6);
            ch  = 8'h00;
            for (int i = 0; i < len; i++) begin
                ch = t_byte'($urandom_range(255));
                if (ch == frp_pkg::ChLf) begin
                    ch = frp_pkg::ChSpace;
                end
                send_item(ch, 1'b0);
            end
            if ($urandom_range(24) == 0) begin
                send_item(ch, 1'b1);
                return;
            end
            send_item(frp_pkg::ChLf, 1'b0);
            prev = "A";
            len  = $urandom_range(0, 20);
            for (int i = 0; i < len; i++) begin
                ch = pick_seq_char(prev);
                send_item(ch, 1'b0);
                prev = ch;
            end
        end
        send_item(t_byte'($urandom_range(255)), 1'b1);
    endtask

    // Arbitrary bytes, closed by an end of stream so the parser recovers.
    task automatic send_noise();
        repeat ($urandom_range(2, 8)) begin
            send_item(t_byte'($urandom_range(255)), $urandom_range(7) == 0);
        end
        send_item(t_byte'($urandom_range(255)), 1'b1);
    endtask

    task automatic run_stream(input int goal);
        int stop_at;
        stop_at = items_sent + goal;
        while (items_sent < stop_at) begin
            if ($urandom_range(7) == 0) begin
                send_noise();
            end else begin
                send_file();
            end
        end
    endtask

    initial begin
        in_ch.valid         = 1'b0;
        in_ch.byte_in       = '0;
        in_ch.end_of_stream = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Blanks, a header with extreme bytes, bases and skipped bytes, a run.
        send_item(frp_pkg::ChSpace, 1'b0);
        send_item(frp_pkg::ChTab, 1'b0);
        send_item(frp_pkg::ChGt, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(frp_pkg::ChLf, 1'b0);
        send_item("A", 1'b0);
        send_item("a", 1'b0);
        send_item("E", 1'b0);
        send_item(8'h80, 1'b0);
        send_item("N", 1'b0);
        send_item("N", 1'b0);
        // A '>' in the bases closes the record; then an empty header and end of stream.
        send_item(frp_pkg::ChGt, 1'b0);
        send_item(frp_pkg::ChLf, 1'b0);
        send_item("c", 1'b0);
        send_item(8'h00, 1'b1);
        // A stray byte before any header, then the ignored error phase.
        send_item(frp_pkg::ChTab, 1'b0);
        send_item("x", 1'b0);
        send_item("G", 1'b0);
        send_item(frp_pkg::ChGt, 1'b0);
        send_item(8'hFF, 1'b1);
        // End of stream while idle, then end of stream inside a header.
        send_item(8'h55, 1'b1);
        send_item(frp_pkg::ChGt, 1'b0);
        send_item("h", 1'b0);
        send_item(8'h00, 1'b1);

        // Random files, alternating the collapse mode; one stretch without stalls.
        set_collapse(1'b1);
        run_stream(175);
        set_collapse(1'b0);
        calm <= 1'b1;
        run_stream(175);
        calm <= 1'b0;
        set_collapse(1'b1);
        run_stream(175);
        set_collapse(1'b0);
        run_stream(175);
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
src/frp_pkg.sv
src/frp_if.sv
src/frp_in_stage.sv
src/frp_decode.sv
src/fasta_record_parser_top.sv
test/frp_checker.sv
test/tb_top.sv
